### hw/rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked in the same cycle, masked while reset is asserted.
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Implication checked in the next cycle, masked while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
// Implication checked in the next cycle, also during reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset-time check failed");
`endif

### hw/rtl/blnd_pkg.sv
// Types, codes and constants of the blend unit.
package blnd_pkg;

  localparam int DIV_BITS = 28;
  localparam int DEN_BITS = 16;
  localparam int RES_BITS = 29;

  localparam logic signed [17:0] FX_ONE  = 18'sd4096;
  localparam logic signed [17:0] FX_HALF = 18'sd2048;

  localparam logic [3:0] MODE_PASS    = 4'd0;
  localparam logic [3:0] MODE_ADD     = 4'd1;
  localparam logic [3:0] MODE_SUB     = 4'd2;
  localparam logic [3:0] MODE_MUL     = 4'd3;
  localparam logic [3:0] MODE_DIV     = 4'd4;
  localparam logic [3:0] MODE_SCREEN  = 4'd5;
  localparam logic [3:0] MODE_OVERLAY = 4'd6;
  localparam logic [3:0] MODE_DODGE   = 4'd7;
  localparam logic [3:0] MODE_BURN    = 4'd8;
  localparam logic [3:0] MODE_MIN     = 4'd9;
  localparam logic [3:0] MODE_MAX     = 4'd10;
  localparam logic [3:0] MODE_DIFF    = 4'd11;
  localparam logic [3:0] MODE_EXCL    = 4'd12;

  // How the last stage forms the result.
  typedef enum logic [2:0] {
    K_DIRECT = 3'd0,
    K_QUOT   = 3'd1,
    K_BURN   = 3'd2,
    K_P12    = 3'd3,
    K_SCR    = 3'd4,
    K_OVL_LO = 3'd5,
    K_OVL_HI = 3'd6,
    K_EXCL   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  sign;
    logic [DIV_BITS-1:0]   num;
    logic [DEN_BITS-1:0]   rem;
    logic [DIV_BITS-1:0]   quo;
    logic [DEN_BITS-1:0]   den;
    logic [31:0]           prod;
    logic [RES_BITS-1:0]   alt;
  } tok_t;

  function automatic logic [RES_BITS-1:0] sx18(logic [17:0] v);
    return {{(RES_BITS-18){v[17]}}, v};
  endfunction

endpackage

### hw/rtl/blnd_chan_if.sv
// Channel interfaces: operand input, result output and mode register write.
interface blnd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] operand_a;
  logic signed [15:0] operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface blnd_out_if;
  logic               valid;
  logic               ready;
  logic signed [28:0] blended;
  modport source (output valid, output blended, input ready);
  modport sink   (input valid, input blended, output ready);
endinterface

interface blnd_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/fixed_point_blend_mode_unit.sv
// Top level of the fixed-point blend unit.
// Takes one operand pair per cycle unless the output stalls, and returns one result
// of 29 bits per item: one entry stage (mode decode and the shared 18x18 multiplier),
// a row of 28 division cells, one quotient bit each, and one output register. Every
// item runs the full row whatever its mode, so results leave in order. The whole
// pipeline advances whenever the output register is empty or being read, so a stalled
// result holds everything behind it. The mode register takes a write in any cycle.
module fixed_point_blend_mode_unit import blnd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  blnd_in_if.sink     in_ch,
  blnd_out_if.source  out_ch,
  blnd_cfg_if.sink    cfg_ch
);

  logic [3:0] mode_r;
  logic       en;
  logic       vld [0:DIV_BITS];
  tok_t       tok [0:DIV_BITS];
  logic       out_vld;
  logic [RES_BITS-1:0] out_res;

  assign en = !out_vld || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld;
  assign out_ch.blended = out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.data;
    end
  end

  blnd_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .mode   (mode_r),
    .a      (in_ch.operand_a),
    .b      (in_ch.operand_b),
    .vld_r  (vld[0]),
    .tok_r  (tok[0])
  );

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    blnd_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (vld[i]),
      .in_tok (tok[i]),
      .vld_r  (vld[i+1]),
      .tok_r  (tok[i+1])
    );
  end

  blnd_post u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (vld[DIV_BITS]),
    .in_tok (tok[DIV_BITS]),
    .vld_r  (out_vld),
    .res_r  (out_res)
  );

endmodule

### hw/rtl/blnd_prep.sv
// Entry stage: decodes the mode, runs the multiplier, sets up the division.
module blnd_prep import blnd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [3:0]         mode,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               vld_r,
  output tok_t               tok_r
);

  logic signed [17:0] ea, eb, mx, my, nb, dv;
  logic [17:0]        nmag, dmag;
  logic signed [35:0] p36;
  tok_t               tok_nxt;
  logic               vld_nxt;

  always_comb begin
    ea = {{2{a[15]}}, a};
    eb = {{2{b[15]}}, b};
    mx = ea;
    my = eb;
    nb = ea;
    dv = eb;
    tok_nxt = '0;
    tok_nxt.kind = K_DIRECT;
    tok_nxt.alt = sx18(ea);
    case (mode)
      MODE_ADD: tok_nxt.alt = sx18(ea + eb);
      MODE_SUB: tok_nxt.alt = sx18(ea - eb);
      MODE_MUL: tok_nxt.kind = K_P12;
      MODE_DIV: begin
        if (eb == 18'sd0) tok_nxt.alt = sx18(FX_ONE);
        else tok_nxt.kind = K_QUOT;
      end
      MODE_SCREEN: begin
        mx = FX_ONE - ea;
        my = FX_ONE - eb;
        tok_nxt.kind = K_SCR;
      end
      MODE_OVERLAY: begin
        if (eb < FX_HALF) begin
          tok_nxt.kind = K_OVL_LO;
        end else begin
          mx = FX_ONE - ea;
          my = FX_ONE - eb;
          tok_nxt.kind = K_OVL_HI;
        end
      end
      MODE_DODGE: begin
        nb = eb;
        dv = FX_ONE - ea;
        if (ea == FX_ONE) tok_nxt.alt = sx18(FX_ONE);
        else tok_nxt.kind = K_QUOT;
      end
      MODE_BURN: begin
        nb = FX_ONE - eb;
        dv = ea;
        if (ea == 18'sd0) tok_nxt.alt = '0;
        else tok_nxt.kind = K_BURN;
      end
      MODE_MIN:  tok_nxt.alt = sx18((ea < eb) ? ea : eb);
      MODE_MAX:  tok_nxt.alt = sx18((ea > eb) ? ea : eb);
      MODE_DIFF: tok_nxt.alt = sx18((eb < ea) ? (ea - eb) : (eb - ea));
      MODE_EXCL: begin
        tok_nxt.kind = K_EXCL;
        tok_nxt.alt = sx18(ea + eb);
      end
      default: tok_nxt.alt = sx18(ea);
    endcase
    // magnitudes stay below 2^16, so the dividend fits 28 bits
    nmag = nb[17] ? 18'(-nb) : nb;
    dmag = dv[17] ? 18'(-dv) : dv;
    tok_nxt.num = {nmag[15:0], 12'b0};
    tok_nxt.den = dmag[DEN_BITS-1:0];
    tok_nxt.sign = nb[17] ^ dv[17];
    p36 = mx * my;
    tok_nxt.prod = p36[31:0];
    vld_nxt = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

### hw/rtl/blnd_div_cell.sv
// One restoring-division cell: produces one quotient bit per item.
module blnd_div_cell import blnd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  tok_t in_tok,
  output logic vld_r,
  output tok_t tok_r
);

  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS+1:0] diff;
  logic                qbit;
  tok_t                tok_nxt;

  always_comb begin
    rem_sh = {in_tok.rem, in_tok.num[DIV_BITS-1]};
    diff = {1'b0, rem_sh} - {2'b0, in_tok.den};
    qbit = !diff[DEN_BITS+1];
    tok_nxt = in_tok;
    tok_nxt.rem = qbit ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
    tok_nxt.num = {in_tok.num[DIV_BITS-2:0], 1'b0};
    tok_nxt.quo = {in_tok.quo[DIV_BITS-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

### hw/rtl/blnd_post.sv
// Output stage: scales the product, signs the quotient, holds the result.
module blnd_post import blnd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  tok_t                in_tok,
  output logic                vld_r,
  output logic [RES_BITS-1:0] res_r
);

  logic signed [31:0]  ps, r12, r11, q12, q11;
  logic [RES_BITS-1:0] qu, qs, one29, res_nxt;

  always_comb begin
    ps = $signed(in_tok.prod);
    // bias negatives so the shift truncates toward zero
    r12 = ps + (ps[31] ? 32'sd4095 : 32'sd0);
    r11 = ps + (ps[31] ? 32'sd2047 : 32'sd0);
    q12 = r12 >>> 12;
    q11 = r11 >>> 11;
    qu = {1'b0, in_tok.quo};
    qs = in_tok.sign ? (~qu + 1'b1) : qu;
    one29 = sx18(FX_ONE);
    case (in_tok.kind)
      K_DIRECT: res_nxt = in_tok.alt;
      K_QUOT:   res_nxt = qs;
      K_BURN:   res_nxt = one29 - qs;
      K_P12:    res_nxt = q12[RES_BITS-1:0];
      K_SCR:    res_nxt = one29 - q12[RES_BITS-1:0];
      K_OVL_LO: res_nxt = q11[RES_BITS-1:0];
      K_OVL_HI: res_nxt = one29 - q11[RES_BITS-1:0];
      K_EXCL:   res_nxt = in_tok.alt - q11[RES_BITS-1:0];
      default:  res_nxt = in_tok.alt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

### hw/rtl/blnd_checker.sv
// Port-level checks of the blend unit and their binding.
`include "assert_macros.svh"
module blnd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [28:0] blended,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  `CHK_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)
  `CHK_SAME(a_in_open_when_empty, clk, rst_n, !out_valid, in_ready)
  `CHK_SAME(a_cfg_always_taken, clk, rst_n, cfg_valid, cfg_ready)
  `CHK_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(blended))

  `CHK_SAME(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready && in_valid, !in_ready)

endmodule

bind fixed_point_blend_mode_unit blnd_checker u_blnd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .blended   (out_ch.blended),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);
